// File: hw/rtl/k_ris_pkg.sv
// ----------------------------------------------------------------------------
// k_ris_pkg: shared types and constants
// Holds the types and default sizes that the interval scheduler files share.
// ----------------------------------------------------------------------------
package k_ris_pkg;

    localparam int DEF_MAX_INTERVALS = 1024;
    localparam int DEF_MAX_SLOTS     = 16;

    localparam int TIME_W  = 32;
    localparam int COUNT_W = 11;
    localparam int CFG_W   = 5;
    localparam int APB_AW  = 3;
    localparam int APB_DW  = 32;

    // Register byte offsets.
    localparam logic [APB_AW-1:0] REG_SLOT_COUNT = 3'd0;

    localparam logic [CFG_W-1:0] SLOT_COUNT_RESET = 5'd1;

    typedef logic [TIME_W-1:0]  t_time;
    typedef logic [COUNT_W-1:0] t_count;

    typedef struct packed {
        t_time start_time;
        t_time finish_time;
    } t_ivl;

    // Commands from the sequencer to the slot scan unit.
    typedef struct packed {
        logic clear_all;
        logic scan_begin;
        logic scan_en;
        logic commit;
    } t_slot_cmd;

endpackage

// File: hw/rtl/k_ris_if.sv
// ----------------------------------------------------------------------------
// k_ris_in_if / k_ris_out_if: beat channels of the interval scheduler
// Valid/ready channels that carry one interval in and one result out.
// ----------------------------------------------------------------------------
interface k_ris_in_if;
    import k_ris_pkg::*;
    logic  valid;
    logic  ready;
    t_time start_time;
    t_time finish_time;
    logic  last_item;

    modport source (output valid, output start_time, output finish_time,
                    output last_item, input ready);
    modport sink   (input valid, input start_time, input finish_time,
                    input last_item, output ready);
endinterface

interface k_ris_out_if;
    import k_ris_pkg::*;
    logic   valid;
    logic   ready;
    t_count selected_count;
    logic   overflow;

    modport source (output valid, output selected_count, output overflow,
                    input ready);
    modport sink   (input valid, input selected_count, input overflow,
                    output ready);
endinterface

// File: hw/rtl/k_resource_interval_scheduler_top.sv
// ----------------------------------------------------------------------------
// k_resource_interval_scheduler_top: greedy interval scheduling on k slots
// Buffers intervals in finish-time order and, on the last beat of a set,
// counts how many a greedy pass can place on the configured resource slots.
// ----------------------------------------------------------------------------
//
//   Channel   Dir  Handshake        Payload
//   i_in      in   valid / ready    start_time, finish_time, last_item
//   o_out     out  valid / ready    selected_count, overflow
//   APB       in   psel / penable   slot_count at byte offset 0
//
// Each input beat is placed into the buffer by insertion: the sequencer walks
// down from the fill level, reading each entry that has a later finish time
// and moving it up one place, and writes the beat where the walk stops, at
// the front of the buffer if every entry is later. A beat dropped on a full
// buffer only sets the overflow flag. The last beat of a set then runs the
// greedy pass: a setup step, then for each buffered interval a read, a scan
// of slot_count slots (slot_count capped at the slot file size) and a booking
// step, all through the one slot comparator, and a last step to post the
// result. Reset is synchronous and active low and empties the buffer; the
// interval memory itself is never cleared. Ready is high only while the
// sequencer is idle, and a finished result waits in the output register
// while further beats are taken; a new result waits for it.
// ----------------------------------------------------------------------------
module k_resource_interval_scheduler_top
    import k_ris_pkg::*;
#(
    parameter int MAX_INTERVALS = DEF_MAX_INTERVALS,
    parameter int MAX_SLOTS     = DEF_MAX_SLOTS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    k_ris_in_if.sink          i_in,
    k_ris_out_if.source       o_out,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    localparam int AW  = $clog2(MAX_INTERVALS);
    localparam int NW  = $clog2(MAX_INTERVALS + 1);
    localparam int SW  = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int SNW = $clog2(MAX_SLOTS + 1);

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_INS_RD = 4'd1;
    localparam logic [3:0] ST_INS_CP = 4'd2;
    localparam logic [3:0] ST_INS_END= 4'd3;
    localparam logic [3:0] ST_G_INIT = 4'd4;
    localparam logic [3:0] ST_G_RD   = 4'd5;
    localparam logic [3:0] ST_G_SCAN = 4'd6;
    localparam logic [3:0] ST_G_BOOK = 4'd7;
    localparam logic [3:0] ST_DONE   = 4'd8;

    // Configuration register. Only the slot count exists; other offsets
    // read as zero and ignore writes.
    logic [CFG_W-1:0] r_slot_count;
    logic             cfg_wr;

    assign cfg_wr = psel && penable && pwrite && (paddr == REG_SLOT_COUNT);
    assign pready = 1'b1;
    assign prdata = (paddr == REG_SLOT_COUNT) ?
                    {{(APB_DW-CFG_W){1'b0}}, r_slot_count} : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot_count <= SLOT_COUNT_RESET;
        end else if (cfg_wr) begin
            r_slot_count <= pwdata[CFG_W-1:0];
        end
    end

    // Slot counts above the slot file size saturate.
    logic [SNW-1:0] slots_eff;
    assign slots_eff = ({4'b0, r_slot_count} > 9'(MAX_SLOTS)) ?
                       SNW'(MAX_SLOTS) : SNW'(r_slot_count);

    // Sequencer state.
    logic [3:0]     r_state, n_state;
    logic [NW-1:0]  r_fill, n_fill;
    logic [NW-1:0]  r_pos, n_pos;
    logic [NW-1:0]  r_count, n_count;
    logic [SNW-1:0] r_scan, n_scan;
    logic           r_ovf, n_ovf;
    logic           r_last, n_last;
    t_ivl           r_new, n_new;
    logic           r_out_valid, n_out_valid;
    t_count         r_out_count, n_out_count;
    logic           r_out_ovf, n_out_ovf;

    // Buffer and slot unit hookup.
    logic          mem_we, mem_re;
    logic [AW-1:0] mem_waddr, mem_raddr;
    t_ivl          mem_wdata, mem_rdata;
    t_slot_cmd     slot_cmd;
    logic          slot_found;
    logic [NW-1:0] pos_m1;
    logic          accept;

    assign pos_m1 = r_pos - NW'(1);
    assign accept = i_in.valid && i_in.ready;
    assign i_in.ready = (r_state == ST_IDLE);

    k_ris_mem #(
        .DEPTH (MAX_INTERVALS),
        .AW    (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    k_ris_slots #(
        .MAX_SLOTS (MAX_SLOTS),
        .SW        (SW)
    ) u_slots (
        .i_clk    (i_clk),
        .i_cmd    (slot_cmd),
        .i_idx    (r_scan[SW-1:0]),
        .i_start  (mem_rdata.start_time),
        .i_finish (mem_rdata.finish_time),
        .o_found  (slot_found)
    );

    always_comb begin
        n_state     = r_state;
        n_fill      = r_fill;
        n_pos       = r_pos;
        n_count     = r_count;
        n_scan      = r_scan;
        n_ovf       = r_ovf;
        n_last      = r_last;
        n_new       = r_new;
        n_out_valid = r_out_valid;
        n_out_count = r_out_count;
        n_out_ovf   = r_out_ovf;
        mem_we      = 1'b0;
        mem_re      = 1'b0;
        mem_waddr   = r_pos[AW-1:0];
        mem_raddr   = pos_m1[AW-1:0];
        mem_wdata   = r_new;
        slot_cmd    = '0;

        if (o_out.valid && o_out.ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_new.start_time  = i_in.start_time;
                    n_new.finish_time = i_in.finish_time;
                    n_last            = i_in.last_item;
                    n_pos             = r_fill;
                    if (r_fill == NW'(MAX_INTERVALS)) begin
                        // Buffer full: the beat is dropped.
                        n_ovf   = 1'b1;
                        n_state = i_in.last_item ? ST_G_INIT : ST_IDLE;
                    end else begin
                        n_state = ST_INS_RD;
                    end
                end
            end
            ST_INS_RD: begin
                if (r_pos == '0) begin
                    mem_we  = 1'b1;
                    n_state = ST_INS_END;
                end else begin
                    mem_re  = 1'b1;
                    n_state = ST_INS_CP;
                end
            end
            ST_INS_CP: begin
                mem_we = 1'b1;
                if (mem_rdata.finish_time > r_new.finish_time) begin
                    mem_wdata = mem_rdata;
                    n_pos     = pos_m1;
                    n_state   = ST_INS_RD;
                end else begin
                    n_state = ST_INS_END;
                end
            end
            ST_INS_END: begin
                n_fill  = r_fill + NW'(1);
                n_state = r_last ? ST_G_INIT : ST_IDLE;
            end
            ST_G_INIT: begin
                slot_cmd.clear_all = 1'b1;
                n_count = '0;
                n_pos   = '0;
                n_state = ((r_fill == '0) || (slots_eff == '0)) ? ST_DONE : ST_G_RD;
            end
            ST_G_RD: begin
                mem_re              = 1'b1;
                mem_raddr           = r_pos[AW-1:0];
                slot_cmd.scan_begin = 1'b1;
                n_scan              = '0;
                n_state             = ST_G_SCAN;
            end
            ST_G_SCAN: begin
                slot_cmd.scan_en = 1'b1;
                n_scan           = r_scan + SNW'(1);
                if (n_scan == slots_eff) begin
                    n_state = ST_G_BOOK;
                end
            end
            ST_G_BOOK: begin
                slot_cmd.commit = 1'b1;
                if (slot_found) begin
                    n_count = r_count + NW'(1);
                end
                n_pos   = r_pos + NW'(1);
                n_state = (n_pos == r_fill) ? ST_DONE : ST_G_RD;
            end
            ST_DONE: begin
                if (!r_out_valid) begin
                    n_out_valid = 1'b1;
                    n_out_count = COUNT_W'(r_count);
                    n_out_ovf   = r_ovf;
                    n_fill      = '0;
                    n_ovf       = 1'b0;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_fill      <= '0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_fill      <= n_fill;
            r_ovf       <= n_ovf;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos       <= n_pos;
        r_count     <= n_count;
        r_scan      <= n_scan;
        r_last      <= n_last;
        r_new       <= n_new;
        r_out_count <= n_out_count;
        r_out_ovf   <= n_out_ovf;
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.selected_count = r_out_count;
    assign o_out.overflow       = r_out_ovf;

endmodule

// File: hw/rtl/k_ris_mem.sv
// ----------------------------------------------------------------------------
// k_ris_mem: interval buffer
// One write port and one read port with registered read data that holds
// until the next read.
// ----------------------------------------------------------------------------
module k_ris_mem
    import k_ris_pkg::*;
#(
    parameter int DEPTH = DEF_MAX_INTERVALS,
    parameter int AW    = $clog2(DEF_MAX_INTERVALS)
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  t_ivl          i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output t_ivl          o_rdata
);

    t_ivl r_mem [DEPTH];
    t_ivl r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: hw/rtl/k_ris_slots.sv
// ----------------------------------------------------------------------------
// k_ris_slots: resource slot file and shared scan comparator
// Visits one slot per cycle, keeping the slot with the largest finish time
// that does not pass the interval's start, and books the interval on it.
// ----------------------------------------------------------------------------
module k_ris_slots
    import k_ris_pkg::*;
#(
    parameter int MAX_SLOTS = DEF_MAX_SLOTS,
    parameter int SW        = 1
) (
    input  logic          i_clk,
    input  t_slot_cmd     i_cmd,
    input  logic [SW-1:0] i_idx,
    input  t_time         i_start,
    input  t_time         i_finish,
    output logic          o_found
);

    t_time         r_slot [MAX_SLOTS];
    logic          r_found;
    logic [SW-1:0] r_best_idx;
    t_time         r_best_val;
    t_time         slot_val;
    logic          better;

    assign slot_val = r_slot[i_idx];
    assign better   = (slot_val <= i_start) && (!r_found || (slot_val > r_best_val));

    always_ff @(posedge i_clk) begin
        if (i_cmd.clear_all) begin
            for (int k = 0; k < MAX_SLOTS; k++) begin
                r_slot[k] <= '0;
            end
        end else if (i_cmd.commit && r_found) begin
            r_slot[r_best_idx] <= i_finish;
        end

        if (i_cmd.scan_begin) begin
            r_found <= 1'b0;
        end else if (i_cmd.scan_en && better) begin
            r_found    <= 1'b1;
            r_best_idx <= i_idx;
            r_best_val <= slot_val;
        end
    end

    assign o_found = r_found;

endmodule

// File: test/k_ris_checker.sv
// ----------------------------------------------------------------------------
// k_ris_checker: result checker for the interval scheduler
// Watches both beat channels and the register port, predicts the greedy
// count for every finished set, and compares each result beat in order.
// ----------------------------------------------------------------------------
module k_ris_checker
    import k_ris_pkg::*;
#(
    parameter int MAX_INTERVALS = DEF_MAX_INTERVALS,
    parameter int MAX_SLOTS     = DEF_MAX_SLOTS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    k_ris_in_if               i_in,
    k_ris_out_if              i_out,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic              pready,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output int                o_errors,
    output int                o_pending
);

    typedef struct packed {
        t_count count;
        logic   ovf;
    } t_sched_result;

    t_ivl          held_q[$];
    logic          ovf_seen;
    logic [CFG_W-1:0] slot_cfg;
    t_sched_result expected_q[$];

    assign o_pending = expected_q.size();

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        o_errors++;
    endtask

    // Sort the held set by finish time and run the greedy slot placement.
    function automatic t_count greedy_count(input t_ivl set_q[$], input int slots);
        t_ivl  sorted[$];
        t_time slot_end[MAX_SLOTS];
        int    best;
        int    pos;
        t_count n;
        n = '0;
        foreach (set_q[i]) begin
            pos = sorted.size();
            while (pos > 0 && sorted[pos-1].finish_time > set_q[i].finish_time) pos--;
            sorted.insert(pos, set_q[i]);
        end
        if (slots > MAX_SLOTS) slots = MAX_SLOTS;
        foreach (slot_end[j]) slot_end[j] = '0;
        foreach (sorted[i]) begin
            best = -1;
            for (int j = 0; j < slots; j++) begin
                if (slot_end[j] <= sorted[i].start_time &&
                    (best < 0 || slot_end[j] > slot_end[best])) best = j;
            end
            if (best >= 0) begin
                slot_end[best] = sorted[i].finish_time;
                n++;
            end
        end
        return n;
    endfunction

    always @(posedge i_clk) begin
        t_ivl iv;
        t_sched_result r, w;
        if (!i_rst_n) begin
            held_q.delete();
            expected_q.delete();
            ovf_seen = 1'b0;
            slot_cfg <= SLOT_COUNT_RESET;
            o_errors = 0;
        end else begin
            if (psel && penable && pwrite && pready && paddr == REG_SLOT_COUNT)
                slot_cfg <= pwdata[CFG_W-1:0];
            if (i_in.valid && i_in.ready) begin
                iv.start_time  = i_in.start_time;
                iv.finish_time = i_in.finish_time;
                if (held_q.size() < MAX_INTERVALS) held_q.push_back(iv);
                else ovf_seen = 1'b1;
                if (i_in.last_item) begin
                    r.count = greedy_count(held_q, slot_cfg);
                    // Overflow only if this or an earlier beat was dropped.
                    r.ovf   = ovf_seen;
                    expected_q.push_back(r);
                    held_q.delete();
                    ovf_seen = 1'b0;
                end
            end
            if (i_out.valid && i_out.ready) begin
                if (expected_q.size() == 0) begin
                    report_mismatch("unexpected result beat", i_out.selected_count, -1);
                end else begin
                    w = expected_q.pop_front();
                    if (i_out.selected_count !== w.count)
                        report_mismatch("selected_count", i_out.selected_count, w.count);
                    if (i_out.overflow !== w.ovf)
                        report_mismatch("overflow", i_out.overflow, w.ovf);
                end
            end
        end
    end

endmodule

// File: test/testbench.sv
// ----------------------------------------------------------------------------
// testbench: top level for the interval scheduler
// Drives interval sets and slot counts into the block, with random idling on
// both sides, and leaves prediction and comparison to the checker.
// ----------------------------------------------------------------------------
module testbench;
    import k_ris_pkg::*;

    localparam int MAXI       = DEF_MAX_INTERVALS;
    localparam int CYCLE_CAP  = 3_000_000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [APB_AW-1:0] paddr = '0;
    logic [APB_DW-1:0] pwdata = '0;
    logic [APB_DW-1:0] prdata;
    logic pready;
    int   errors, pending;
    int   cycles = 0;
    bit   calm = 1'b0;     // When set, neither side idles.
    bit   hold_sink = 1'b0; // Long receiver hold-off.

    k_ris_in_if  in_ch ();
    k_ris_out_if out_ch ();

    always #10 i_clk = ~i_clk;

    k_resource_interval_scheduler_top dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(in_ch.sink), .o_out(out_ch.source),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    k_ris_checker chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(in_ch), .i_out(out_ch),
        .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
        .paddr(paddr), .pwdata(pwdata), .o_errors(errors), .o_pending(pending)
    );

    initial begin
        in_ch.valid = 1'b0;
        in_ch.start_time = '0;
        in_ch.finish_time = '0;
        in_ch.last_item = 1'b0;
        out_ch.ready = 1'b0;
    end

    // The cycle counter is the watchdog: a hung block ends the run as a failure.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Receiver: idles about a third of the time unless calm, and stays off for
    // the whole of a hold-off so the block fills and stalls its input.
    always @(negedge i_clk) begin
        out_ch.ready <= !hold_sink && (calm || $urandom_range(99) >= 32);
    end

    // Register write: setup cycle, then access cycle.
    task automatic write_slot_count(input int value);
        @(negedge i_clk);
        psel <= 1'b1; pwrite <= 1'b1; paddr <= REG_SLOT_COUNT; pwdata <= APB_DW'(value);
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    endtask

    // Offers one interval beat and holds it until the block takes it. Valid
    // stays high after the beat so the next call can follow without a gap;
    // callers drop it once the stream pauses.
    task automatic send_interval(input t_time s, input t_time f, input logic last);
        while (!calm && $urandom_range(99) < 32) begin
            in_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.start_time <= s;
        in_ch.finish_time <= f;
        in_ch.last_item <= last;
        do @(posedge i_clk); while (!in_ch.ready);
        @(negedge i_clk);
    endtask

    // Stops offering beats and lets every expected result drain.
    task automatic drain();
        in_ch.valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    // A set of random intervals. Short spans keep many placements possible;
    // some draws use the full 32-bit range so every bit toggles.
    task automatic send_random_set(input int n);
        t_time s, f;
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(3) == 0) begin
                s = $urandom; f = $urandom;
            end else begin
                s = $urandom_range(200); f = s + $urandom_range(60);
            end
            send_interval(s, f, i == n - 1);
        end
    endtask

    initial begin
        int n;
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: extremes, finish before start, equal finishes, single beat.
        send_interval(32'd0, 32'd0, 1'b1);
        send_interval(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
        send_interval(32'd5, 32'd10, 1'b0);
        send_interval(32'd5, 32'd10, 1'b0);
        send_interval(32'd10, 32'd3, 1'b0);
        send_interval(32'd0, 32'hFFFF_FFFF, 1'b1);
        drain();
        write_slot_count(0);   // No slots: every interval is skipped.
        send_interval(32'd0, 32'd1, 1'b0);
        send_interval(32'd1, 32'd2, 1'b1);
        drain();
        write_slot_count(31);  // Saturates to the full slot count.
        for (int i = 0; i < 18; i++) send_interval(i, i + 5, i == 17);
        drain();

        // Overflow: one set beyond the buffer, the last beat itself dropped.
        calm = 1'b1;
        write_slot_count(16);
        for (int i = 0; i <= MAXI; i++) send_interval(i, i, i == MAXI);
        drain();
        calm = 1'b0;

        // Random sets across slot counts.
        for (int k = 0; k < 30; k++) begin
            if (k % 10 == 0) begin
                drain();
                write_slot_count(k == 0 ? 1 : $urandom_range(20));
            end
            if (k == 10) calm = 1'b1;
            if (k == 15) calm = 1'b0;
            if (k == 20) begin
                fork
                    begin hold_sink = 1'b1; repeat (3000) @(negedge i_clk);
                          hold_sink = 1'b0; end
                join_none
            end
            n = $urandom_range(1, 6);
            send_random_set(n);
        end
        in_ch.valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (200) @(negedge i_clk);
        if (errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// File: files.f
hw/rtl/k_ris_pkg.sv
hw/rtl/k_ris_if.sv
hw/rtl/k_ris_mem.sv
hw/rtl/k_ris_slots.sv
hw/rtl/k_resource_interval_scheduler_top.sv
test/k_ris_checker.sv
test/testbench.sv
